// File: hw/rtl/hbpq_pkg.sv
// ============================================================================
// hbpq_pkg
// shared types, codes and the ordering function of the binary heap queue
// ============================================================================
package hbpq_pkg;

    localparam int unsigned VAL_W   = 32;   // key width
    localparam int unsigned REQ_W   = 2;    // request code width
    localparam int unsigned PADDR_W = 3;    // config byte address width
    localparam int unsigned PDATA_W = 32;   // config data width

    // request codes, code 3 is unused and ignored
    localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EXTRACT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK    = 2'd2;

    // config register indexes and reset values
    localparam logic REG_MIN_MODE = 1'b0;
    localparam logic MIN_MODE_RST = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_RD,
        S_DN_CMP,
        S_PEEK,
        S_RESP
    } t_state;

    // true when key a belongs above key b in the selected order
    function automatic logic key_above(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b,
        input logic                    min_mode
    );
        return min_mode ? (a < b) : (a > b);
    endfunction

endpackage

// File: hw/rtl/hbpq_if.sv
// ============================================================================
// hbpq request and response channels
// valid/ready channels that carry heap requests and their results
// ============================================================================
interface hbpq_req_if import hbpq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface hbpq_rsp_if import hbpq_pkg::*; #(
    parameter int unsigned CNT_W = 9
) ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] top_value;
    logic [1:0]              status;
    logic [CNT_W-1:0]        count;

    modport source (output valid, output top_value, output status, output count,
                    input ready);
    modport sink   (input valid, input top_value, input status, input count,
                    output ready);
endinterface

// File: hw/rtl/hbpq_kmem.sv
// ============================================================================
// hbpq_kmem
// key store: one write port, two read ports, registered read data
// ============================================================================
module hbpq_kmem import hbpq_pkg::*; #(
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned ADDR_W = 8
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [ADDR_W-1:0]       i_waddr,
    input  logic signed [VAL_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]       i_raddr_a,
    input  logic [ADDR_W-1:0]       i_raddr_b,
    output logic signed [VAL_W-1:0] o_rdata_a,
    output logic signed [VAL_W-1:0] o_rdata_b
);

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rdata_a;
    logic signed [VAL_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: hw/rtl/hbpq_apb.sv
// ============================================================================
// hbpq_apb
// apb register slave holding the heap order mode
// ============================================================================
module hbpq_apb import hbpq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic               o_min_mode
);

    logic r_min_mode;
    logic w_sel_mode;

    // register index is the word address
    assign w_sel_mode = (paddr[PADDR_W-1:2] == REG_MIN_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mode <= MIN_MODE_RST;
        end else if (psel && penable && pwrite && w_sel_mode) begin
            r_min_mode <= pwdata[0];
        end
    end

    assign prdata     = w_sel_mode ? {{(PDATA_W-1){1'b0}}, r_min_mode} : '0;
    assign pready     = 1'b1;
    assign o_min_mode = r_min_mode;

endmodule

// File: hw/rtl/hbpq_ctrl.sv
// ============================================================================
// hbpq_ctrl
// request sequencer: sift-up and sift-down walks over the key store
// ============================================================================
module hbpq_ctrl import hbpq_pkg::*; #(
    parameter int unsigned CAPACITY = 256,
    parameter int unsigned ADDR_W   = 8,
    parameter int unsigned CNT_W    = 9
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_min_mode,
    hbpq_req_if.sink                i_req,
    hbpq_rsp_if.source              o_rsp,
    output logic                    o_we,
    output logic [ADDR_W-1:0]       o_waddr,
    output logic signed [VAL_W-1:0] o_wdata,
    output logic [ADDR_W-1:0]       o_raddr_a,
    output logic [ADDR_W-1:0]       o_raddr_b,
    input  logic signed [VAL_W-1:0] i_rdata_a,
    input  logic signed [VAL_W-1:0] i_rdata_b
);

    localparam int unsigned IDX_W = ADDR_W + 2;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [ADDR_W-1:0]       r_pos, n_pos;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic signed [VAL_W-1:0] r_top, n_top;
    t_status                 r_status, n_status;
    logic                    r_ovalid, n_ovalid;
    logic signed [VAL_W-1:0] r_otop, n_otop;
    t_status                 r_ostatus, n_ostatus;
    logic [CNT_W-1:0]        r_ocount, n_ocount;

    logic                    w_accept;
    logic                    w_full, w_empty;
    logic                    w_slot_free;
    logic [ADDR_W-1:0]       w_parent;
    logic [ADDR_W-1:0]       w_last;
    logic [IDX_W-1:0]        w_lc, w_rc, w_n;
    logic                    w_lc_ok, w_rc_ok;
    logic                    w_u_up, w_l_up, w_r_up, w_move;
    logic signed [VAL_W-1:0] w_bestv;
    logic [ADDR_W-1:0]       w_bidx;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_slot_free = !r_ovalid || o_rsp.ready;

    assign w_parent = ADDR_W'((r_pos - ADDR_W'(1)) >> 1);
    assign w_last   = ADDR_W'(r_count - CNT_W'(1));
    assign w_lc     = {1'b0, r_pos, 1'b1};
    assign w_rc     = w_lc + IDX_W'(1);
    assign w_n      = IDX_W'(r_count);
    assign w_lc_ok  = (w_lc < w_n);
    assign w_rc_ok  = (w_rc < w_n);

    // sift-up: moving key against its parent
    assign w_u_up  = key_above(r_key, i_rdata_a, i_min_mode);
    // sift-down: left child first, right child against the winner
    assign w_l_up  = key_above(i_rdata_a, r_key, i_min_mode);
    assign w_bestv = w_l_up ? i_rdata_a : r_key;
    assign w_r_up  = w_rc_ok && key_above(i_rdata_b, w_bestv, i_min_mode);
    assign w_move  = w_l_up || w_r_up;
    assign w_bidx  = w_r_up ? w_rc[ADDR_W-1:0] : w_lc[ADDR_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.req_type)
                        REQ_INSERT:  n_state = w_full  ? S_RESP : S_UP_RD;
                        REQ_EXTRACT: n_state = w_empty ? S_RESP : S_DN_LOAD;
                        REQ_PEEK:    n_state = w_empty ? S_RESP : S_PEEK;
                        default:     n_state = S_RESP;
                    endcase
                end
            end
            S_UP_RD:   n_state = (r_pos == '0) ? S_RESP : S_UP_CMP;
            S_UP_CMP:  n_state = w_u_up ? S_UP_RD : S_RESP;
            S_DN_LOAD: n_state = S_DN_RD;
            S_DN_RD:   n_state = w_lc_ok ? S_DN_CMP : S_RESP;
            S_DN_CMP:  n_state = w_move ? S_DN_RD : S_RESP;
            S_PEEK:    n_state = S_RESP;
            S_RESP:    n_state = w_slot_free ? S_IDLE : S_RESP;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath, memory port and result register
    always_comb begin
        n_count   = r_count;
        n_pos     = r_pos;
        n_key     = r_key;
        n_top     = r_top;
        n_status  = r_status;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        n_otop    = r_otop;
        n_ostatus = r_ostatus;
        n_ocount  = r_ocount;
        o_we      = 1'b0;
        o_waddr   = r_pos;
        o_wdata   = r_key;
        o_raddr_a = '0;
        o_raddr_b = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_top    = '0;
                    n_status = ST_OK;
                    unique case (i_req.req_type)
                        REQ_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_pos   = ADDR_W'(r_count);
                                n_key   = i_req.value;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        REQ_EXTRACT: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count   = r_count - CNT_W'(1);
                                o_raddr_a = '0;
                                o_raddr_b = w_last;
                            end
                        end
                        REQ_PEEK: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    o_we = 1'b1;
                end else begin
                    o_raddr_a = w_parent;
                end
            end
            S_UP_CMP: begin
                o_we = 1'b1;
                if (w_u_up) begin
                    o_wdata = i_rdata_a;
                    n_pos   = w_parent;
                end
            end
            S_DN_LOAD: begin
                n_top = i_rdata_a;
                n_key = i_rdata_b;
                n_pos = '0;
            end
            S_DN_RD: begin
                if (w_lc_ok) begin
                    o_raddr_a = w_lc[ADDR_W-1:0];
                    o_raddr_b = w_rc[ADDR_W-1:0];
                end else begin
                    o_we = 1'b1;
                end
            end
            S_DN_CMP: begin
                o_we = 1'b1;
                if (w_move) begin
                    o_wdata = w_r_up ? i_rdata_b : i_rdata_a;
                    n_pos   = w_bidx;
                end
            end
            S_PEEK: begin
                n_top = i_rdata_a;
            end
            S_RESP: begin
                if (w_slot_free) begin
                    n_ovalid  = 1'b1;
                    n_otop    = r_top;
                    n_ostatus = r_status;
                    n_ocount  = r_count;
                end
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_key     <= n_key;
        r_top     <= n_top;
        r_status  <= n_status;
        r_otop    <= n_otop;
        r_ostatus <= n_ostatus;
        r_ocount  <= n_ocount;
    end

    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.top_value = r_otop;
    assign o_rsp.status    = r_ostatus;
    assign o_rsp.count     = r_ocount;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_dn_child: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DN_CMP) |-> w_lc_ok)
        else $error("sift-down compare without a left child");

    a_up_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_CMP) |-> ((r_pos != '0) && (IDX_W'(r_pos) < w_n)))
        else $error("sift-up compare at root or beyond count");

    a_load_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PEEK || r_state == S_DN_LOAD) |-> ($past(r_state) == S_IDLE))
        else $error("root read data used without a read from idle");

endmodule

// File: hw/rtl/binary_heap_priority_queue.sv
// ============================================================================
// binary_heap_priority_queue
// array-backed binary heap priority queue with insert, extract and peek
// ============================================================================
// Keys are signed 32-bit values held in a heap array in one synchronous
// key store with a registered read. Each request transaction on i_req gives
// exactly one result transaction on o_rsp, in order. An insert writes the
// key into a hole at the tail and walks it up; each level climbed is a
// parent read, then a compare and write. An extract reads the root and the
// last key together on the two read ports, then walks the last key down
// from the root; each level is a read of both children on the two read
// ports, then a compare and write. A peek reads the root, and requests
// answered from the count alone (full insert, empty extract or peek, unused
// code) go straight to the result. With CAPACITY = 256 the slowest request
// is an insert whose key climbs all eight levels to the root. The key store's
// single write port and registered read make each level a read, then a write.
// One request is processed at a time; a finished result waits in the output
// register while the next request is accepted. The order mode (min_mode,
// word 0 of the apb space, reset to min-heap) must be written only while the
// queue is idle; keys already held are not reordered on a change.
// The key store needs no clear after reset: only entries below the count are
// ever read.
// ============================================================================
module binary_heap_priority_queue import hbpq_pkg::*; #(
    parameter int unsigned CAPACITY = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // request and result channels
    hbpq_req_if.sink           i_req,
    hbpq_rsp_if.source         o_rsp
);

    // address covers the array, count also holds CAPACITY itself
    localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

    logic                    w_min_mode;
    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr;
    logic signed [VAL_W-1:0] w_wdata;
    logic [ADDR_W-1:0]       w_raddr_a;
    logic [ADDR_W-1:0]       w_raddr_b;
    logic signed [VAL_W-1:0] w_rdata_a;
    logic signed [VAL_W-1:0] w_rdata_b;

    // order mode register
    hbpq_apb u_apb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_min_mode (w_min_mode)
    );

    // heap array
    hbpq_kmem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_kmem (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // request sequencer with the sift walks and the result register
    hbpq_ctrl #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_min_mode (w_min_mode),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr_a  (w_raddr_a),
        .o_raddr_b  (w_raddr_b),
        .i_rdata_a  (w_rdata_a),
        .i_rdata_b  (w_rdata_b)
    );

endmodule
